>>> rtl/grc_pkg.sv
// grc_pkg: shared types, codes and constants of the grid ray caster
// no dependencies; imported by every module of the block
package grc_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_POS_X       = 3'd0,
    CFG_POS_Y       = 3'd1,
    CFG_VIEW_DIR_X  = 3'd2,
    CFG_VIEW_DIR_Y  = 3'd3,
    CFG_CAM_PLANE_X = 3'd4,
    CFG_CAM_PLANE_Y = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CAM, S_MUL, S_RAY, S_DXS, S_DXW, S_DYS, S_DYW,
    S_SIDE, S_STEP, S_READ, S_HS, S_HW, S_OUT
  } back_state_e;

  localparam int unsigned QW         = 32;   // divider numerator and quotient
  localparam int unsigned DW         = 30;   // divider denominator
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam logic [23:0] DIST_MAX   = 24'hFFFFFF;
  localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;
  localparam logic [7:0]  WALL_LEVEL = 8'd48;
  localparam logic [QW-1:0] RECIP_ONE = 32'h4000_0000;

  typedef struct packed {
    logic [21:0]        pos_x;
    logic [21:0]        pos_y;
    logic signed [15:0] view_dir_x;
    logic signed [15:0] view_dir_y;
    logic signed [15:0] cam_plane_x;
    logic signed [15:0] cam_plane_y;
  } cfg_t;

  // classified command on its way from front to back
  typedef struct packed {
    logic       is_cast;
    logic       in_grid;
    logic [9:0] column;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [9:0]  ray_column;
    logic        hit_side;
    logic [23:0] wall_distance;
    logic [15:0] wall_height;
    logic [5:0]  hit_row;
    logic [5:0]  hit_col;
    logic [7:0]  hit_value;
    logic        left_grid;
  } res_t;

  typedef struct packed {
    logic          start;
    logic [QW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

  function automatic logic [23:0] sat24(input logic [QW-1:0] v);
    sat24 = (v > QW'(DIST_MAX)) ? DIST_MAX : v[23:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [QW-1:0] v);
    sat16 = (v > QW'(HEIGHT_MAX)) ? HEIGHT_MAX : v[15:0];
  endfunction

endpackage

>>> rtl/grc_front.sv
// grc_front: accepts command beats and classifies them for the back end
// depends on grc_pkg
module grc_front #(
  parameter int unsigned GRID_SIDE = 64
) (
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  logic              command_i,
  input  logic [9:0]        column_i,
  input  logic [5:0]        cell_row_i,
  input  logic [5:0]        cell_col_i,
  input  logic [7:0]        cell_value_i,
  output logic              push_o,
  output grc_pkg::item_t    item_o,
  input  logic              full_i
);
  import grc_pkg::*;

  // accept whenever the queue has room
  assign cmd_ready_o = !full_i;
  assign push_o      = cmd_valid_i && !full_i;

  // tag writes that land inside the grid
  always_comb begin
    item_o.is_cast = command_i;
    item_o.in_grid = (32'(cell_row_i) < GRID_SIDE) && (32'(cell_col_i) < GRID_SIDE);
    item_o.column  = column_i;
    item_o.row     = cell_row_i;
    item_o.col     = cell_col_i;
    item_o.value   = cell_value_i;
  end

endmodule

>>> rtl/grc_fifo.sv
// grc_fifo: short command queue between front and back
// depends on grc_pkg
module grc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  grc_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output grc_pkg::item_t pop_item_o,
  output logic           valid_o
);
  import grc_pkg::*;

  item_t                store_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_AW:0]     count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o     = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = store_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill count
  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop  ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/grc_div.sv
// grc_div: restoring divider, one quotient bit per cycle
// depends on grc_pkg; shared by the reciprocal and height divisions
module grc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  grc_pkg::div_req_t req_i,
  output grc_pkg::div_rsp_t rsp_o
);
  import grc_pkg::*;

  localparam int unsigned CNTW = $clog2(QW);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [QW-1:0]   num_q, quot_q;
  logic [DW-1:0]   den_q, rem_q;
  logic [DW:0]     rem_sh, rem_nx;
  logic            ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_q, num_q[QW-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNTW'(QW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[QW-2:0], 1'b0};
      rem_q  <= rem_nx[DW-1:0];
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

>>> rtl/grc_back.sv
// grc_back: map store and cast engine (ray setup, grid walk, height)
// depends on grc_pkg and grc_div
module grc_back #(
  parameter int unsigned GRID_SIDE      = 64,
  parameter int unsigned SCREEN_COLUMNS = 1024,
  parameter int unsigned SCREEN_ROWS    = 768
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  grc_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  grc_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           res_valid_o,
  output grc_pkg::res_t  res_o,
  input  logic           res_ready_i
);
  import grc_pkg::*;

  localparam int unsigned AW    = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int unsigned GB    = ($clog2(GRID_SIDE) > 6) ? $clog2(GRID_SIDE) : 6;
  localparam int unsigned CW    = GB + 2;           // signed cell coordinate
  localparam int unsigned SW    = 24 + GB + 2;      // side distance accumulator
  localparam int unsigned CMW   = 26;               // camera value
  localparam int unsigned PW    = 42;               // plane times camera
  localparam int unsigned RW    = 29;               // ray component
  localparam int unsigned CELLS = GRID_SIDE * GRID_SIDE;
  // camera divide by the column count as a reciprocal multiply, exact for
  // 25-bit numerators
  localparam int unsigned CAM_S = 25 + $clog2(SCREEN_COLUMNS);
  localparam longint unsigned CAM_M =
    ((64'd1 << CAM_S) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS);

  back_state_e state_q, state_d;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [7:0]            mem [CELLS];
  logic [7:0]            rd_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         waddr, raddr;

  logic [9:0]            col_q;
  logic [50:0]           cam_prod, cam_quot;
  logic signed [CMW-1:0] cam_q;
  logic signed [PW-1:0]  prx_q, pry_q;
  logic signed [RW-1:0]  rx_q, ry_q;
  logic signed [DW-1:0]  rx_ext, ry_ext;
  logic [DW-1:0]         mag_x, mag_y;
  logic [23:0]           dx_q, dy_q;
  logic [SW-1:0]         sx_q, sy_q;
  logic signed [CW-1:0]  cx_q, cy_q, ncx, ncy;
  logic                  side_q, left_q, step_x, step_out, hit, load_res;
  logic [16:0]           fx_sel, fy_sel;
  logic [40:0]           mul_x, mul_y;
  logic [SW-1:0]         dist_raw;
  logic [23:0]           dist_q;
  logic [15:0]           height_q;
  logic [7:0]            hval_q;
  logic                  res_valid_q;
  res_t                  res_q;

  grc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // camera quotient 2*column*2^14 / columns
  always_comb begin
    cam_prod = 51'({col_q, 15'd0}) * 51'(CAM_M);
    cam_quot = cam_prod >> CAM_S;
  end

  // ray magnitudes for the reciprocals
  always_comb begin
    rx_ext = DW'(rx_q);
    ry_ext = DW'(ry_q);
    mag_x  = rx_ext[DW-1] ? DW'(-rx_ext) : DW'(rx_ext);
    mag_y  = ry_ext[DW-1] ? DW'(-ry_ext) : DW'(ry_ext);
  end

  // first side distance products
  always_comb begin
    fx_sel = rx_q[RW-1] ? {1'b0, cfg_i.pos_x[15:0]} : 17'h10000 - {1'b0, cfg_i.pos_x[15:0]};
    fy_sel = ry_q[RW-1] ? {1'b0, cfg_i.pos_y[15:0]} : 17'h10000 - {1'b0, cfg_i.pos_y[15:0]};
    mul_x  = 41'(fx_sel) * 41'(dx_q);
    mul_y  = 41'(fy_sel) * 41'(dy_q);
  end

  // one grid step: axis choice, next cell, bounds, map addresses, hit test, distance
  always_comb begin
    if (rx_q == '0) begin
      step_x = 1'b0;
    end else if (ry_q == '0) begin
      step_x = 1'b1;
    end else begin
      step_x = (sx_q < sy_q);
    end
    ncx = cx_q;
    ncy = cy_q;
    if (step_x) begin
      ncx = rx_q[RW-1] ? cx_q - CW'(1) : cx_q + CW'(1);
    end else begin
      ncy = ry_q[RW-1] ? cy_q - CW'(1) : cy_q + CW'(1);
    end
    step_out = ncx[CW-1] || ncy[CW-1] ||
               (ncx >= $signed(CW'(GRID_SIDE))) || (ncy >= $signed(CW'(GRID_SIDE)));
    raddr    = AW'(int'(ncy) * GRID_SIDE + int'(ncx));
    waddr    = AW'(int'(item_i.row) * GRID_SIDE + int'(item_i.col));
    hit      = (rd_q > WALL_LEVEL);
    dist_raw = side_q ? sy_q - SW'(dy_q) : sx_q - SW'(dx_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (item_valid_i && item_i.is_cast) state_d = S_CAM;
      S_CAM:  state_d = S_MUL;
      S_MUL:  state_d = S_RAY;
      S_RAY:  state_d = S_DXS;
      S_DXS:  state_d = (mag_x != '0) ? S_DXW : S_DYS;
      S_DXW:  if (div_rsp.done) state_d = S_DYS;
      S_DYS:  state_d = (mag_y != '0) ? S_DYW : S_SIDE;
      S_DYW:  if (div_rsp.done) state_d = S_SIDE;
      S_SIDE: state_d = S_STEP;
      S_STEP: state_d = (left_q || step_out) ? S_OUT : S_READ;
      S_READ: state_d = hit ? S_HS : S_STEP;
      S_HS:   state_d = (dist_q != '0) ? S_HW : S_OUT;
      S_HW:   if (div_rsp.done) state_d = S_OUT;
      S_OUT:  if (load_res) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_pop_o  = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    load_res    = 1'b0;
    div_req     = '0;
    case (state_q)
      S_IDLE: begin
        item_pop_o = item_valid_i;
        mem_we     = item_valid_i && !item_i.is_cast && item_i.in_grid;
      end
      S_DXS: begin
        div_req.start = (mag_x != '0);
        div_req.num   = RECIP_ONE;
        div_req.den   = mag_x;
      end
      S_DYS: begin
        div_req.start = (mag_y != '0);
        div_req.num   = RECIP_ONE;
        div_req.den   = mag_y;
      end
      S_STEP: mem_re = !left_q && !step_out;
      S_HS: begin
        div_req.start = (dist_q != '0);
        div_req.num   = QW'(SCREEN_ROWS) << 16;
        div_req.den   = DW'(dist_q);
      end
      S_OUT: load_res = !res_valid_q || res_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // map store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= item_i.value;
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  // cast datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: col_q <= item_i.column;
      S_CAM:  cam_q <= $signed({1'b0, cam_quot[CMW-2:0]}) - CMW'(16384);
      S_MUL: begin
        prx_q <= PW'(cfg_i.cam_plane_x) * PW'(cam_q);
        pry_q <= PW'(cfg_i.cam_plane_y) * PW'(cam_q);
      end
      S_RAY: begin
        rx_q <= RW'(cfg_i.view_dir_x) + RW'(prx_q >>> 14);
        ry_q <= RW'(cfg_i.view_dir_y) + RW'(pry_q >>> 14);
      end
      S_DXS: if (mag_x == '0) dx_q <= DIST_MAX;
      S_DXW: if (div_rsp.done) dx_q <= sat24(div_rsp.quot);
      S_DYS: if (mag_y == '0) dy_q <= DIST_MAX;
      S_DYW: if (div_rsp.done) dy_q <= sat24(div_rsp.quot);
      S_SIDE: begin
        sx_q   <= SW'(mul_x >> 16);
        sy_q   <= SW'(mul_y >> 16);
        cx_q   <= CW'(cfg_i.pos_x[21:16]);
        cy_q   <= CW'(cfg_i.pos_y[21:16]);
        side_q <= 1'b0;
        left_q <= (32'(cfg_i.pos_x[21:16]) >= GRID_SIDE) ||
                  (32'(cfg_i.pos_y[21:16]) >= GRID_SIDE);
      end
      S_STEP: begin
        if (!left_q) begin
          left_q <= step_out;
          cx_q   <= ncx;
          cy_q   <= ncy;
          side_q <= !step_x;
          if (step_x) begin
            sx_q <= sx_q + SW'(dx_q);
          end else begin
            sy_q <= sy_q + SW'(dy_q);
          end
        end
      end
      S_READ: begin
        hval_q <= rd_q;
        dist_q <= (dist_raw > SW'(DIST_MAX)) ? DIST_MAX : dist_raw[23:0];
      end
      S_HS: if (dist_q == '0) height_q <= HEIGHT_MAX;
      S_HW: if (div_rsp.done) height_q <= sat16(div_rsp.quot);
      default: ;
    endcase
  end

  // result register, frees the engine while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q.ray_column    <= col_q;
      res_q.left_grid     <= left_q;
      res_q.hit_side      <= left_q ? 1'b0  : side_q;
      res_q.wall_distance <= left_q ? 24'd0 : dist_q;
      res_q.wall_height   <= left_q ? 16'd0 : height_q;
      res_q.hit_row       <= left_q ? 6'd0  : cy_q[5:0];
      res_q.hit_col       <= left_q ? 6'd0  : cx_q[5:0];
      res_q.hit_value     <= left_q ? 8'd0  : hval_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // queue is only drained between casts
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> state_q == S_IDLE)
    else $error("command popped while a cast is in flight");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_left_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.left_grid) |->
      (res_q.wall_distance == '0 && res_q.hit_value == '0 && res_q.wall_height == '0))
    else $error("grid exit result carries hit fields");

  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.left_grid && res_q.wall_distance == '0) |->
      res_q.wall_height == HEIGHT_MAX)
    else $error("zero distance without saturated height");

endmodule

>>> rtl/grid_dda_ray_caster.sv
// grid_dda_ray_caster: top level, configuration registers and stream ports
// depends on grc_pkg, grc_front, grc_fifo, grc_back
//
// Map writes and column casts enter on one stream and are handled in order.
// A write is done in the back end's idle state. A cast forms its camera
// value by a constant reciprocal multiply, then runs one shared 32-bit
// restoring divider up to three times (two reciprocals, line height); a
// zero ray component or a zero distance skips its division. The grid walk
// passes a step state, then a map read, for each cell entered. A
// four-entry queue lets commands arrive while a cast runs, and an output
// register lets the next cast start while a result waits. The map has no
// reset; every cell a ray can reach must be written first.
module grid_dda_ray_caster #(
  parameter int unsigned GRID_SIDE      = 64,
  parameter int unsigned SCREEN_COLUMNS = 1024,
  parameter int unsigned SCREEN_ROWS    = 768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // column, cell_row, cell_col, cell_value, zero pad
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // ray_column, hit_side, wall_distance, wall_height,
                                      // hit_row, hit_col, hit_value, zero pad
  output logic        m_axis_tuser,   // left_grid
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [21:0] cfg_data_i
);
  import grc_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, pop_item;
  logic  push, full, pop, qvalid;
  res_t  res;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x       <= 22'd2129920;
      cfg_q.pos_y       <= 22'd2129920;
      cfg_q.view_dir_x  <= 16'sd16384;
      cfg_q.view_dir_y  <= 16'sd0;
      cfg_q.cam_plane_x <= 16'sd0;
      cfg_q.cam_plane_y <= 16'sd10813;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POS_X:       cfg_q.pos_x       <= cfg_data_i;
        CFG_POS_Y:       cfg_q.pos_y       <= cfg_data_i;
        CFG_VIEW_DIR_X:  cfg_q.view_dir_x  <= cfg_data_i[15:0];
        CFG_VIEW_DIR_Y:  cfg_q.view_dir_y  <= cfg_data_i[15:0];
        CFG_CAM_PLANE_X: cfg_q.cam_plane_x <= cfg_data_i[15:0];
        CFG_CAM_PLANE_Y: cfg_q.cam_plane_y <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  grc_front #(.GRID_SIDE(GRID_SIDE)) u_front (
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_o  (s_axis_tready),
    .command_i    (s_axis_tuser),
    .column_i     (s_axis_tdata[9:0]),
    .cell_row_i   (s_axis_tdata[15:10]),
    .cell_col_i   (s_axis_tdata[21:16]),
    .cell_value_i (s_axis_tdata[29:22]),
    .push_o       (push),
    .item_o       (push_item),
    .full_i       (full)
  );

  grc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .valid_o     (qvalid)
  );

  grc_back #(
    .GRID_SIDE      (GRID_SIDE),
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (qvalid),
    .item_i       (pop_item),
    .item_pop_o   (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  // result beat packing
  assign m_axis_tdata = {1'b0, res.hit_value, res.hit_col, res.hit_row, res.wall_height,
                         res.wall_distance, res.hit_side, res.ray_column};
  assign m_axis_tuser = res.left_grid;

endmodule
